### src/box_overlap_ratio_unit_macros.svh
// Assertion macros for the box overlap ratio unit checkers.
// Depends on nothing; included by the checker file.
`ifndef BOX_OVERLAP_RATIO_UNIT_MACROS_SVH
`define BOX_OVERLAP_RATIO_UNIT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define BOR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bor assertion failed");

// Concurrent assertion that is also checked while reset is high.
`define BOR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bor assertion failed");

`endif

### src/bor_pkg.sv
// Package for the box overlap ratio unit: default widths and command codes.
// Depends on nothing; used by the interfaces, the divider and the top level.
`timescale 1ns / 1ps

package bor_pkg;

   localparam int COORD_BITS_DEF = 13;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic {
      CMD_IOU = 1'b0,
      CMD_IOA = 1'b1
   } cmd_type;

endpackage

### src/bor_if.sv
// Request and response channel interfaces of the box overlap ratio unit.
// Depends on bor_pkg for default widths and the command type.
`timescale 1ns / 1ps

interface bor_req_if import bor_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   cmd_type               command;
   logic [COORD_BITS-1:0] first_left;
   logic [COORD_BITS-1:0] first_top;
   logic [COORD_BITS-1:0] first_width;
   logic [COORD_BITS-1:0] first_height;
   logic [COORD_BITS-1:0] second_left;
   logic [COORD_BITS-1:0] second_top;
   logic [COORD_BITS-1:0] second_width;
   logic [COORD_BITS-1:0] second_height;

   modport source (
      output valid, command, first_left, first_top, first_width, first_height,
             second_left, second_top, second_width, second_height,
      input  ready
   );
   modport sink (
      input  valid, command, first_left, first_top, first_width, first_height,
             second_left, second_top, second_width, second_height,
      output ready
   );
endinterface

interface bor_rsp_if import bor_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) ();
   logic                      valid;
   logic                      ready;
   logic [FRAC_BITS:0]        ratio;
   logic [2*COORD_BITS:0]     overlap_area;

   modport source (output valid, ratio, overlap_area, input ready);
   modport sink (input valid, ratio, overlap_area, output ready);
endinterface

### src/bor_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on bor_pkg for default widths; used by box_overlap_ratio_unit.
`timescale 1ns / 1ps

module bor_divider import bor_pkg::*; #(
   parameter int NUM_BITS  = 2 * COORD_BITS_DEF,
   parameter int DEN_BITS  = 2 * COORD_BITS_DEF + 1,
   parameter int QUOT_BITS = FRAC_BITS_DEF + 1,
   parameter int TAG_BITS  = 2 * COORD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [NUM_BITS-1:0]  in_num,
   input  logic [DEN_BITS-1:0]  in_den,
   input  logic [TAG_BITS-1:0]  in_tag,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [QUOT_BITS-1:0] out_quot,
   output logic [TAG_BITS-1:0]  out_tag
);

   localparam int TRIAL_BITS = DEN_BITS + 1;

   // The numerator never exceeds the denominator, so each partial remainder
   // stays below the denominator and its double fits in TRIAL_BITS.
   logic                 valid_ff [QUOT_BITS];
   logic [DEN_BITS-1:0]  rem_ff   [QUOT_BITS];
   logic [DEN_BITS-1:0]  den_ff   [QUOT_BITS];
   logic [QUOT_BITS-1:0] quot_ff  [QUOT_BITS];
   logic [TAG_BITS-1:0]  tag_ff   [QUOT_BITS];
   logic                 adv      [QUOT_BITS+1];

   assign adv[QUOT_BITS] = out_ready;
   assign in_ready       = adv[0];

   for (genvar j = 0; j < QUOT_BITS; j++) begin : g_stage
      logic                  prev_valid;
      logic [TRIAL_BITS-1:0] trial;
      logic [DEN_BITS-1:0]   prev_den;
      logic [QUOT_BITS-1:0]  prev_quot;
      logic [TAG_BITS-1:0]   prev_tag;
      logic                  take;
      logic [TRIAL_BITS-1:0] diff;
      logic [DEN_BITS-1:0]   rem_in;
      logic [QUOT_BITS-1:0]  quot_in;

      if (j == 0) begin : g_first
         assign prev_valid = in_valid;
         assign trial      = TRIAL_BITS'(in_num);
         assign prev_den   = in_den;
         assign prev_quot  = '0;
         assign prev_tag   = in_tag;
      end else begin : g_next
         assign prev_valid = valid_ff[j-1];
         assign trial      = {rem_ff[j-1], 1'b0};
         assign prev_den   = den_ff[j-1];
         assign prev_quot  = quot_ff[j-1];
         assign prev_tag   = tag_ff[j-1];
      end

      assign adv[j] = !valid_ff[j] || adv[j+1];

      always_comb begin
         diff    = trial - {1'b0, prev_den};
         take    = (trial >= {1'b0, prev_den});
         rem_in  = take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
         quot_in = {prev_quot[QUOT_BITS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (adv[j]) begin
            valid_ff[j] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[j]) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= prev_den;
            quot_ff[j] <= quot_in;
            tag_ff[j]  <= prev_tag;
         end
      end
   end

   assign out_valid = valid_ff[QUOT_BITS-1];
   assign out_quot  = quot_ff[QUOT_BITS-1];
   assign out_tag   = tag_ff[QUOT_BITS-1];

endmodule

### src/box_overlap_ratio_unit.sv
// Channel    | Dir | Contents of one beat
// req_if     | in  | command, first box and second box (left, top, width, height)
// rsp_if     | out | ratio (FRAC_BITS fraction bits), overlap_area
//
// One beat is accepted per cycle while rsp_if is not stalled; each beat passes
// through four geometry stages, then one divider stage per quotient bit.
// Reset clears every stage valid bit synchronously.
// A stall on rsp_if holds each full stage; empty stages still fill.
// Top level of the box overlap ratio unit; depends on bor_pkg, bor_if and
// bor_divider.
`timescale 1ns / 1ps

module box_overlap_ratio_unit import bor_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   bor_req_if.sink  req_if,
   bor_rsp_if.source rsp_if
);

   localparam int EDGE_BITS = COORD_BITS + 1;
   localparam int AREA_BITS = 2 * COORD_BITS;
   localparam int DEN_BITS  = AREA_BITS + 1;
   localparam int QUOT_BITS = FRAC_BITS + 1;

   logic adv1, adv2, adv3, adv4, div_ready;

   // Stage 1: overlap edges.
   logic                  s1_valid_ff;
   cmd_type               s1_cmd_ff;
   logic [EDGE_BITS-1:0]  s1_left_ff, s1_top_ff, s1_right_ff, s1_bottom_ff;
   logic [EDGE_BITS-1:0]  s1_left_in, s1_top_in, s1_right_in, s1_bottom_in;
   logic [EDGE_BITS-1:0]  right1, right2, bottom1, bottom2;
   logic [COORD_BITS-1:0] s1_w1_ff, s1_h1_ff, s1_w2_ff, s1_h2_ff;

   // Stage 2: overlap extent.
   logic                  s2_valid_ff;
   cmd_type               s2_cmd_ff;
   logic [COORD_BITS-1:0] s2_iw_ff, s2_ih_ff, s2_iw_in, s2_ih_in;
   logic [EDGE_BITS-1:0]  span_w, span_h;
   logic [COORD_BITS-1:0] s2_w1_ff, s2_h1_ff, s2_w2_ff, s2_h2_ff;

   // Stage 3: areas.
   logic                  s3_valid_ff;
   cmd_type               s3_cmd_ff;
   logic [AREA_BITS-1:0]  s3_inter_ff, s3_area1_ff, s3_area2_ff;

   // Stage 4: denominator.
   logic                  s4_valid_ff;
   logic [AREA_BITS-1:0]  s4_inter_ff;
   logic [DEN_BITS-1:0]   s4_den_ff, s4_den_in, union_area;

   logic [QUOT_BITS-1:0]  div_quot;
   logic [AREA_BITS-1:0]  div_tag;

   assign adv4          = !s4_valid_ff || div_ready;
   assign adv3          = !s3_valid_ff || adv4;
   assign adv2          = !s2_valid_ff || adv3;
   assign adv1          = !s1_valid_ff || adv2;
   assign req_if.ready  = adv1;

   always_comb begin
      right1       = EDGE_BITS'(req_if.first_left) + EDGE_BITS'(req_if.first_width);
      right2       = EDGE_BITS'(req_if.second_left) + EDGE_BITS'(req_if.second_width);
      bottom1      = EDGE_BITS'(req_if.first_top) + EDGE_BITS'(req_if.first_height);
      bottom2      = EDGE_BITS'(req_if.second_top) + EDGE_BITS'(req_if.second_height);
      s1_left_in   = (req_if.first_left > req_if.second_left) ?
                     EDGE_BITS'(req_if.first_left) : EDGE_BITS'(req_if.second_left);
      s1_top_in    = (req_if.first_top > req_if.second_top) ?
                     EDGE_BITS'(req_if.first_top) : EDGE_BITS'(req_if.second_top);
      s1_right_in  = (right1 < right2) ? right1 : right2;
      s1_bottom_in = (bottom1 < bottom2) ? bottom1 : bottom2;
   end

   // The overlap width never exceeds either box width, so it fits a coordinate.
   always_comb begin
      span_w = s1_right_ff - s1_left_ff;
      span_h = s1_bottom_ff - s1_top_ff;
      if ((s1_left_ff < s1_right_ff) && (s1_top_ff < s1_bottom_ff)) begin
         s2_iw_in = span_w[COORD_BITS-1:0];
         s2_ih_in = span_h[COORD_BITS-1:0];
      end else begin
         s2_iw_in = '0;
         s2_ih_in = '0;
      end
   end

   // A zero denominator only occurs with a zero overlap, and dividing zero by
   // one gives the required zero ratio.
   always_comb begin
      union_area = DEN_BITS'(s3_area1_ff) + DEN_BITS'(s3_area2_ff)
                   - DEN_BITS'(s3_inter_ff);
      case (s3_cmd_ff)
         CMD_IOU: s4_den_in = union_area;
         CMD_IOA: s4_den_in = DEN_BITS'(s3_area2_ff);
         default: s4_den_in = union_area;
      endcase
      if (s4_den_in == '0) begin
         s4_den_in = DEN_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (adv1) begin
            s1_valid_ff <= req_if.valid;
         end
         if (adv2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (adv3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (adv4) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_cmd_ff    <= req_if.command;
         s1_left_ff   <= s1_left_in;
         s1_top_ff    <= s1_top_in;
         s1_right_ff  <= s1_right_in;
         s1_bottom_ff <= s1_bottom_in;
         s1_w1_ff     <= req_if.first_width;
         s1_h1_ff     <= req_if.first_height;
         s1_w2_ff     <= req_if.second_width;
         s1_h2_ff     <= req_if.second_height;
      end
      if (adv2) begin
         s2_cmd_ff <= s1_cmd_ff;
         s2_iw_ff  <= s2_iw_in;
         s2_ih_ff  <= s2_ih_in;
         s2_w1_ff  <= s1_w1_ff;
         s2_h1_ff  <= s1_h1_ff;
         s2_w2_ff  <= s1_w2_ff;
         s2_h2_ff  <= s1_h2_ff;
      end
      if (adv3) begin
         s3_cmd_ff   <= s2_cmd_ff;
         s3_inter_ff <= AREA_BITS'(s2_iw_ff) * AREA_BITS'(s2_ih_ff);
         s3_area1_ff <= AREA_BITS'(s2_w1_ff) * AREA_BITS'(s2_h1_ff);
         s3_area2_ff <= AREA_BITS'(s2_w2_ff) * AREA_BITS'(s2_h2_ff);
      end
      if (adv4) begin
         s4_inter_ff <= s3_inter_ff;
         s4_den_ff   <= s4_den_in;
      end
   end

   bor_divider #(
      .NUM_BITS  (AREA_BITS),
      .DEN_BITS  (DEN_BITS),
      .QUOT_BITS (QUOT_BITS),
      .TAG_BITS  (AREA_BITS)
   ) u_bor_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid_ff),
      .in_ready  (div_ready),
      .in_num    (s4_inter_ff),
      .in_den    (s4_den_ff),
      .in_tag    (s4_inter_ff),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_quot  (div_quot),
      .out_tag   (div_tag)
   );

   assign rsp_if.ratio        = div_quot;
   assign rsp_if.overlap_area = (AREA_BITS + 1)'(div_tag);

endmodule

### src/bor_checker.sv
// Port-level checker for the box overlap ratio unit, bound to the top level.
// Depends on bor_pkg and box_overlap_ratio_unit_macros.svh.
`timescale 1ns / 1ps
`include "box_overlap_ratio_unit_macros.svh"

module bor_checker import bor_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [FRAC_BITS:0]    rsp_ratio,
   input logic [2*COORD_BITS:0] rsp_overlap_area
);

   localparam logic [FRAC_BITS:0] RATIO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   `BOR_ASSERT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `BOR_ASSERT(a_ratio_max, clock, reset, rsp_valid |-> rsp_ratio <= RATIO_ONE)
   `BOR_ASSERT(a_no_overlap_zero, clock, reset, rsp_valid && rsp_overlap_area == '0 |-> rsp_ratio == '0)
   `BOR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind box_overlap_ratio_unit bor_checker #(
   .COORD_BITS (COORD_BITS),
   .FRAC_BITS  (FRAC_BITS)
) u_bor_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_ratio        (rsp_if.ratio),
   .rsp_overlap_area (rsp_if.overlap_area)
);

### test/testbench.sv
// Self-checking testbench for box_overlap_ratio_unit: directed and random box pairs
// are checked against a predictor of the intersection area and the overlap ratio.
// Depends on bor_pkg, the bor_req_if and bor_rsp_if interfaces and the unit itself.
`timescale 1ns / 1ps

module testbench;
   import bor_pkg::*;

   localparam int COORD          = COORD_BITS_DEF;
   localparam int FRAC           = FRAC_BITS_DEF;
   localparam int MAX_COORD      = (1 << COORD) - 1;
   localparam int DRAIN_CYCLES   = 5 + FRAC + 10;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STALL_LIMIT    = 4000;

   typedef struct packed {
      cmd_type          command;
      logic [COORD-1:0] first_left;
      logic [COORD-1:0] first_top;
      logic [COORD-1:0] first_width;
      logic [COORD-1:0] first_height;
      logic [COORD-1:0] second_left;
      logic [COORD-1:0] second_top;
      logic [COORD-1:0] second_width;
      logic [COORD-1:0] second_height;
   } box_pair_type;

   typedef struct packed {
      logic [FRAC:0]    ratio;
      logic [2*COORD:0] overlap_area;
   } overlap_result_type;

   logic clock;
   logic reset;

   bor_req_if #(.COORD_BITS(COORD)) req_chan ();
   bor_rsp_if #(.COORD_BITS(COORD), .FRAC_BITS(FRAC)) rsp_chan ();

   box_overlap_ratio_unit #(.COORD_BITS(COORD), .FRAC_BITS(FRAC)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   overlap_result_type overlap_results_due[$];
   int unsigned        mismatch_count;
   int unsigned        req_idle_pct;
   int unsigned        rsp_idle_pct;
   int unsigned        hold_off_requests;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic overlap_result_type predict_overlap(box_pair_type p);
      overlap_result_type r;
      longint unsigned    l1, t1, w1, h1, l2, t2, w2, h2;
      longint unsigned    left, top, right, bottom, inter, area1, area2, den, quotient;
      l1 = p.first_left;
      t1 = p.first_top;
      w1 = p.first_width;
      h1 = p.first_height;
      l2 = p.second_left;
      t2 = p.second_top;
      w2 = p.second_width;
      h2 = p.second_height;
      left   = (l1 > l2) ? l1 : l2;
      top    = (t1 > t2) ? t1 : t2;
      right  = (l1 + w1 < l2 + w2) ? l1 + w1 : l2 + w2;
      bottom = (t1 + h1 < t2 + h2) ? t1 + h1 : t2 + h2;
      inter  = 0;
      if (left < right && top < bottom) begin
         inter = (right - left) * (bottom - top);
      end
      area1 = w1 * h1;
      area2 = w2 * h2;
      den = (p.command == CMD_IOU) ? area1 + area2 - inter : area2;
      quotient = (den == 0) ? 0 : (inter << FRAC) / den;
      r.ratio        = quotient[FRAC:0];
      r.overlap_area = inter[2*COORD:0];
      return r;
   endfunction

   function automatic box_pair_type make_pair(cmd_type command,
                                              int unsigned l1, int unsigned t1,
                                              int unsigned w1, int unsigned h1,
                                              int unsigned l2, int unsigned t2,
                                              int unsigned w2, int unsigned h2);
      box_pair_type p;
      p.command       = command;
      p.first_left    = COORD'(l1);
      p.first_top     = COORD'(t1);
      p.first_width   = COORD'(w1);
      p.first_height  = COORD'(h1);
      p.second_left   = COORD'(l2);
      p.second_top    = COORD'(t2);
      p.second_width  = COORD'(w2);
      p.second_height = COORD'(h2);
      return p;
   endfunction

   // Most pairs are placed near each other, so they often overlap or touch;
   // a minority are fully random in both position and size.
   function automatic box_pair_type random_box_pair();
      box_pair_type p;
      int unsigned  kind;
      int unsigned  span;
      kind = $urandom_range(99);
      p.command     = cmd_type'($urandom_range(1));
      p.first_left  = COORD'($urandom);
      p.first_top   = COORD'($urandom);
      if (kind < 15) begin
         p.first_width   = COORD'($urandom);
         p.first_height  = COORD'($urandom);
         p.second_left   = COORD'($urandom);
         p.second_top    = COORD'($urandom);
         p.second_width  = COORD'($urandom);
         p.second_height = COORD'($urandom);
      end else begin
         span = (kind < 30) ? MAX_COORD : ((kind < 70) ? 63 : 1023);
         p.first_width   = COORD'($urandom_range(span));
         p.first_height  = COORD'($urandom_range(span));
         p.second_width  = COORD'($urandom_range(span));
         p.second_height = COORD'($urandom_range(span));
         p.second_left   = p.first_left + COORD'($urandom_range(2 * span)) - COORD'(span);
         p.second_top    = p.first_top + COORD'($urandom_range(2 * span)) - COORD'(span);
         if (kind >= 85 && kind < 90) begin
            p.second_left   = p.first_left;
            p.second_top    = p.first_top;
            p.second_width  = p.first_width;
            p.second_height = p.first_height;
         end else if (kind >= 90 && kind < 95) begin
            p.second_left = p.first_left + p.first_width;
         end else if (kind >= 95) begin
            p.second_top = p.first_top + p.first_height;
         end
      end
      return p;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_box_pair(box_pair_type p);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.command       <= p.command;
      req_chan.first_left    <= p.first_left;
      req_chan.first_top     <= p.first_top;
      req_chan.first_width   <= p.first_width;
      req_chan.first_height  <= p.first_height;
      req_chan.second_left   <= p.second_left;
      req_chan.second_top    <= p.second_top;
      req_chan.second_width  <= p.second_width;
      req_chan.second_height <= p.second_height;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic test_directed_cases();
      send_box_pair(make_pair(CMD_IOU, 0, 0, MAX_COORD, MAX_COORD, 0, 0, MAX_COORD, MAX_COORD));
      send_box_pair(make_pair(CMD_IOA, 0, 0, MAX_COORD, MAX_COORD, 0, 0, MAX_COORD, MAX_COORD));
      send_box_pair(make_pair(CMD_IOU, 0, 0, 0, 0, 0, 0, 0, 0));
      send_box_pair(make_pair(CMD_IOA, 0, 0, 0, 0, 0, 0, 0, 0));
      send_box_pair(make_pair(CMD_IOU, MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD,
                              MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD));
      send_box_pair(make_pair(CMD_IOA, 0, 0, MAX_COORD, MAX_COORD,
                              MAX_COORD, MAX_COORD, 1, 1));
      send_box_pair(make_pair(CMD_IOU, 0, 0, 100, 100, 100, 0, 100, 100));
      send_box_pair(make_pair(CMD_IOA, 0, 0, 100, 100, 0, 100, 100, 100));
      send_box_pair(make_pair(CMD_IOU, 10, 10, 0, 50, 0, 0, 40, 40));
      send_box_pair(make_pair(CMD_IOA, 10, 10, 50, 0, 0, 0, 40, 40));
      send_box_pair(make_pair(CMD_IOA, 0, 0, 40, 40, 10, 10, 0, 20));
      send_box_pair(make_pair(CMD_IOU, 5, 5, 10, 10, 0, 0, 40, 40));
      send_box_pair(make_pair(CMD_IOA, 5, 5, 10, 10, 0, 0, 40, 40));
      send_box_pair(make_pair(CMD_IOA, 0, 0, 40, 40, 5, 5, 10, 10));
      send_box_pair(make_pair(CMD_IOU, 0, 0, 3, 3, 1, 1, 3, 3));
      send_box_pair(make_pair(CMD_IOA, 0, 0, 3, 7, 1, 2, 3, 3));
      send_box_pair(make_pair(CMD_IOU, 0, 0, 10, 10, 8000, 8000, 10, 10));
      send_box_pair(make_pair(CMD_IOU, 'h1555, 'h0AAA, 'h1555, 'h0AAA,
                              'h0AAA, 'h1555, 'h0AAA, 'h1555));
      send_box_pair(make_pair(CMD_IOA, 'h0AAA, 'h1555, 'h0AAA, 'h1555,
                              'h1555, 'h0AAA, 'h1555, 'h0AAA));
      send_box_pair(make_pair(CMD_IOU, 77, 33, 1, 1, 77, 33, 1, 1));
      send_box_pair(make_pair(CMD_IOU, 0, 0, MAX_COORD, 1, 0, 0, 1, MAX_COORD));
   endtask

   task automatic test_random_pairs(int unsigned count);
      repeat (count) send_box_pair(random_box_pair());
   endtask

   // The receiver holds off for a long stretch while beats keep coming, so the
   // pipeline fills and the unit must stall its input.
   task automatic test_output_backpressure();
      hold_off_requests++;
      repeat (80) send_box_pair(random_box_pair());
   endtask

   initial begin
      int unsigned served;
      int unsigned hold_left;
      served = 0;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_requests != served) begin
            served = hold_off_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      overlap_result_type want;
      box_pair_type       pair;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (overlap_results_due.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected beat: ratio %0d, overlap_area %0d", $time,
                        rsp_chan.ratio, rsp_chan.overlap_area);
            end else begin
               want = overlap_results_due.pop_front();
               if (rsp_chan.ratio !== want.ratio) begin
                  mismatch_count++;
                  $display("%0t ratio mismatch: expected %0d, actual %0d", $time,
                           want.ratio, rsp_chan.ratio);
               end
               if (rsp_chan.overlap_area !== want.overlap_area) begin
                  mismatch_count++;
                  $display("%0t overlap_area mismatch: expected %0d, actual %0d", $time,
                           want.overlap_area, rsp_chan.overlap_area);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            pair.command       = req_chan.command;
            pair.first_left    = req_chan.first_left;
            pair.first_top     = req_chan.first_top;
            pair.first_width   = req_chan.first_width;
            pair.first_height  = req_chan.first_height;
            pair.second_left   = req_chan.second_left;
            pair.second_top    = req_chan.second_top;
            pair.second_width  = req_chan.second_width;
            pair.second_height = req_chan.second_height;
            overlap_results_due = {overlap_results_due, predict_overlap(pair)};
         end
      end
   end

   initial begin
      int unsigned stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("box_overlap_ratio_unit regression: fail");
      $finish;
   end

   initial begin
      mismatch_count    = 0;
      hold_off_requests = 0;
      req_idle_pct      = 37;
      rsp_idle_pct      = 77;
      reset             = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.command       = CMD_IOU;
      req_chan.first_left    = '0;
      req_chan.first_top     = '0;
      req_chan.first_width   = '0;
      req_chan.first_height  = '0;
      req_chan.second_left   = '0;
      req_chan.second_top    = '0;
      req_chan.second_width  = '0;
      req_chan.second_height = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_cases();
      test_random_pairs(150);
      req_idle_pct = 77;
      rsp_idle_pct = 37;
      test_random_pairs(150);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_output_backpressure();
      test_random_pairs(50);
      req_chan.valid <= 1'b0;

      while (overlap_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("box_overlap_ratio_unit regression: pass");
      end else begin
         $display("box_overlap_ratio_unit regression: fail");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/bor_pkg.sv
src/bor_if.sv
src/bor_divider.sv
src/box_overlap_ratio_unit.sv
src/bor_checker.sv
test/testbench.sv
